### hdl/aesv_pkg.sv
// ----------------------------------------------------------------------------
// aesv_pkg: shared types, constants and field functions
// GF(2^8) arithmetic modulo 0x169, S-box tables built at elaboration.
// ----------------------------------------------------------------------------
package aesv_pkg;

	localparam int unsigned ROUND_COUNT = 10;
	localparam int unsigned KEY_DEPTH = ROUND_COUNT + 1;
	localparam int unsigned KEY_AW = $clog2(KEY_DEPTH);
	localparam logic [8:0] FIELD_POLY = 9'h169;
	localparam logic [7:0] AFFINE_CONST = 8'h15;

	// register indexes of the configuration port
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW = 1'b1;

	typedef logic [0:15][7:0] blk_t;     // byte 0 in the top bits
	typedef logic [7:0] sbox_tab_t [256];

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		logic [8:0] t;
		t = {x, 1'b0};
		if (x[7]) begin
			t = t ^ FIELD_POLY;
		end
		return t[7:0];
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] x;
		r = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				r = r ^ x;
			end
			x = gf_dbl(x);
		end
		return r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	// forward table: field inverse, then affine map
	function automatic sbox_tab_t gen_sbox();
		sbox_tab_t tab;
		logic [7:0] r;
		logic [7:0] base;
		logic [7:0] e;
		for (int v = 0; v < 256; v++) begin
			r = 8'd1;
			base = v[7:0];
			e = 8'd254;
			for (int k = 0; k < 8; k++) begin
				if (e[k]) begin
					r = gf_mul(r, base);
				end
				base = gf_mul(base, base);
			end
			tab[v] = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4)
				^ AFFINE_CONST;
		end
		return tab;
	endfunction

	// inverse table: invert the forward table entry by entry
	function automatic sbox_tab_t gen_inv_sbox();
		sbox_tab_t fwd;
		sbox_tab_t tab;
		fwd = gen_sbox();
		for (int v = 0; v < 256; v++) begin
			tab[fwd[v]] = v[7:0];
		end
		return tab;
	endfunction

	localparam sbox_tab_t SBOX = gen_sbox();
	localparam sbox_tab_t INV_SBOX = gen_inv_sbox();

	function automatic blk_t shift_rows(input blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4 * c + r] = s[4 * ((c + r) % 4) + r];
			end
		end
		return t;
	endfunction

	function automatic blk_t inv_shift_rows(input blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4 * ((c + r) % 4) + r] = s[4 * c + r];
			end
		end
		return t;
	endfunction

	function automatic blk_t mix_columns(input blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4 * c + r] = gf_mul(s[4 * c + r], 8'h02)
					^ gf_mul(s[4 * c + ((r + 1) % 4)], 8'h03)
					^ s[4 * c + ((r + 2) % 4)]
					^ s[4 * c + ((r + 3) % 4)];
			end
		end
		return t;
	endfunction

	function automatic blk_t inv_mix_columns(input blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4 * c + r] = gf_mul(s[4 * c + r], 8'h0e)
					^ gf_mul(s[4 * c + ((r + 1) % 4)], 8'h0b)
					^ gf_mul(s[4 * c + ((r + 2) % 4)], 8'h0d)
					^ gf_mul(s[4 * c + ((r + 3) % 4)], 8'h09);
			end
		end
		return t;
	endfunction

endpackage

### hdl/aesv_ram.sv
// ----------------------------------------------------------------------------
// aesv_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data appears in the next cycle.
// ----------------------------------------------------------------------------
module aesv_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/aes128_variant_block_cipher.sv
// ----------------------------------------------------------------------------
// aes128_variant_block_cipher: AES-128 structure over GF(2^8) mod 0x169
// Round keys live in two RAMs (high and low halves), expanded on key write.
//
//   channel   | handshake          | payload
//   ----------+--------------------+----------------------------------
//   request   | start / busy       | opcode, data_high, data_low
//   result    | done (one cycle)   | result_high, result_low
//   config    | cfg_we             | cfg_index, cfg_wdata
//
// A block runs one key addition and ten rounds, one per cycle,
// each fed by one read of both round-key RAMs. done pulses the cycle after
// the last round, and a new request may be accepted in that same cycle.
// A key write expands all round keys, one per cycle, busy high.
// Reset clears the key registers; the round-key RAMs hold nothing until the
// first key write.
// ----------------------------------------------------------------------------
module aes128_variant_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        opcode,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata
);

	import aesv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EXPAND = 3'b010,
		ST_RUN    = 3'b100
	} fsm_t;

	fsm_t              state_q;
	logic [KEY_AW-1:0] cnt_q;
	logic              dec_q;
	logic              done_q;
	blk_t              blk_q;
	logic [63:0]       key_high_q;
	logic [63:0]       key_low_q;
	logic [127:0]      w_q;
	logic [7:0]        rcon_q;

	logic              accept;
	logic [KEY_AW-1:0] raddr;
	logic [KEY_AW-1:0] nxt_cnt;
	logic [63:0]       rk_high;
	logic [63:0]       rk_low;
	blk_t              rk;
	blk_t              blk_nxt;
	blk_t              enc_t;
	blk_t              dec_t;
	logic [31:0]       temp_w;
	logic [127:0]      w_nxt;
	logic [127:0]      key_new;
	logic              last;

	assign accept = start && (state_q == ST_IDLE) && !cfg_we;
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result_high = blk_q[0:7];
	assign result_low = blk_q[8:15];
	assign nxt_cnt = cnt_q + KEY_AW'(1);
	assign last = (cnt_q == KEY_AW'(ROUND_COUNT));

	// pick the round key for the next step
	always_comb begin
		if (accept) begin
			raddr = opcode ? KEY_AW'(ROUND_COUNT) : '0;
		end else if (last) begin
			raddr = '0;
		end else if (dec_q) begin
			raddr = KEY_AW'(ROUND_COUNT) - nxt_cnt;
		end else begin
			raddr = nxt_cnt;
		end
	end

	aesv_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_ram_high (
		.clk   (clk),
		.we    (state_q == ST_EXPAND),
		.waddr (cnt_q),
		.wdata (w_q[127:64]),
		.raddr (raddr),
		.rdata (rk_high)
	);

	aesv_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_ram_low (
		.clk   (clk),
		.we    (state_q == ST_EXPAND),
		.waddr (cnt_q),
		.wdata (w_q[63:0]),
		.raddr (raddr),
		.rdata (rk_low)
	);

	assign rk = {rk_high, rk_low};

	// one cipher round, or the bare key addition on the first step
	always_comb begin
		blk_t sb;
		blk_t isb;
		blk_t sr;
		sr = shift_rows(blk_q);
		for (int i = 0; i < 16; i++) begin
			sb[i] = SBOX[sr[i]];
		end
		enc_t = last ? sb : mix_columns(sb);
		enc_t = enc_t ^ rk;
		isb = inv_shift_rows(blk_q);
		for (int i = 0; i < 16; i++) begin
			isb[i] = INV_SBOX[isb[i]];
		end
		isb = isb ^ rk;
		dec_t = last ? isb : inv_mix_columns(isb);
		if (cnt_q == '0) begin
			blk_nxt = blk_q ^ rk;
		end else begin
			blk_nxt = dec_q ? dec_t : enc_t;
		end
	end

	// next four key words from the current four
	always_comb begin
		logic [31:0] rot;
		rot = {w_q[23:0], w_q[31:24]};
		temp_w = {SBOX[rot[31:24]] ^ rcon_q, SBOX[rot[23:16]], SBOX[rot[15:8]],
			SBOX[rot[7:0]]};
		w_nxt[127:96] = w_q[127:96] ^ temp_w;
		w_nxt[95:64] = w_q[95:64] ^ w_nxt[127:96];
		w_nxt[63:32] = w_q[63:32] ^ w_nxt[95:64];
		w_nxt[31:0] = w_q[31:0] ^ w_nxt[63:32];
	end

	// merge the written register into the key
	always_comb begin
		unique case (cfg_index)
			REG_KEY_HIGH: key_new = {cfg_wdata, key_low_q};
			REG_KEY_LOW:  key_new = {key_high_q, cfg_wdata};
			default:      key_new = {key_high_q, key_low_q};
		endcase
	end

	// control: key writes restart expansion, requests run eleven steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			dec_q <= 1'b0;
			done_q <= 1'b0;
			key_high_q <= '0;
			key_low_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				key_high_q <= key_new[127:64];
				key_low_q <= key_new[63:0];
				state_q <= ST_EXPAND;
				cnt_q <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept) begin
							state_q <= ST_RUN;
							cnt_q <= '0;
							dec_q <= opcode;
						end
					end
					ST_EXPAND: begin
						cnt_q <= nxt_cnt;
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
					ST_RUN: begin
						cnt_q <= nxt_cnt;
						if (last) begin
							state_q <= ST_IDLE;
							done_q <= 1'b1;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath: block register and key words
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= {data_high, data_low};
		end else if (state_q == ST_RUN) begin
			blk_q <= blk_nxt;
		end
		if (cfg_we) begin
			w_q <= key_new;
			rcon_q <= 8'h01;
		end else if (state_q == ST_EXPAND) begin
			w_q <= w_nxt;
			rcon_q <= gf_dbl(rcon_q);
		end
	end

endmodule

### hdl/aesv_checker.sv
// ----------------------------------------------------------------------------
// aesv_checker: port-level checks for the cipher block
// Watches handshake and result timing on the top-level ports.
// ----------------------------------------------------------------------------
module aesv_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_we
);

	// accepted request keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> busy)
		else $error("request accepted but block not busy");

	// key write starts expansion
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("key write did not start expansion");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// result follows work and frees the block
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done without preceding work");

endmodule

bind aes128_variant_block_cipher aesv_checker u_aesv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.cfg_we (cfg_we)
);
